>>> hw/rtl/bfba_pkg.sv
package bfba_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIT,
    ST_MOD,
    ST_TOTAL,
    ST_COMMIT_A,
    ST_FIND,
    ST_MERGE,
    ST_COMMIT_F,
    ST_DONE
  } state_t;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOFIT    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  localparam logic REG_POOL_SIZE = 1'b0;

  localparam int          ALIGN_BITS = 17;
  localparam logic [31:0] POOL_RESET = 32'd65536;

endpackage

>>> hw/rtl/best_fit_block_allocator.sv
// Best-fit block allocator over a pool of pool_size units, with merging of freed blocks.
// Commands: allocate (smallest free block of at least size+alignment, lowest start on
// ties), free (by padding offset) and query. Each command takes one result beat. Each
// item scans the tables through their registered-read memories (allocate and query one
// scan, free up to two), and an allocate that fits adds a bit-serial remainder of the
// block start by the alignment.
// After reset and after each pool_size write the tables are set up in the init state.
module best_fit_block_allocator #(
  parameter int FREE_ENTRIES = 64,
  parameter int USED_ENTRIES = 64,
  parameter int OFFSET_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] request_size,
  input  logic [16:0] alignment,
  input  logic [31:0] release_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] padding_offset,
  output logic [31:0] aligned_offset,
  output logic [31:0] total_size
);

  localparam int OW = OFFSET_BITS;
  localparam int CW = (OW > 33) ? OW : 33;
  localparam int FA = $clog2(FREE_ENTRIES);
  localparam int UA = $clog2(USED_ENTRIES);
  localparam int SN = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int IW = $clog2(SN + 1);
  localparam int AB = bfba_pkg::ALIGN_BITS;

  bfba_pkg::state_t state, state_next;

  logic [31:0] pool_size;
  logic        cfg_we;

  logic [1:0]    cmd_q;
  logic [31:0]   size_q;
  logic [AB-1:0] align_q;
  logic [31:0]   rel_q;
  logic [CW-1:0] need_q;

  logic [IW-1:0] cnt;
  logic          pipe_vld;
  logic [IW-1:0] pipe_idx;
  logic          scan_end;
  logic          scan_run;

  logic [FREE_ENTRIES-1:0] free_valid;
  logic [FREE_ENTRIES-1:0] fv_merge;
  logic [USED_ENTRIES-1:0] used_valid;

  logic          fr_we, ur_we;
  logic [FA-1:0] fr_waddr;
  logic [UA-1:0] ur_waddr;
  logic [2*OW-1:0] fr_wdata, ur_wdata, fr_rdata, ur_rdata;
  logic [OW-1:0] f_st, f_len, u_st, u_len, f_end;

  logic          best_found;
  logic [FA-1:0] best_idx;
  logic [OW-1:0] best_start, best_len;
  logic          ue_found;
  logic [UA-1:0] ue_idx;
  logic          fe_found;
  logic [FA-1:0] fe_idx;
  logic          ub_found;
  logic [UA-1:0] ub_idx;
  logic [OW-1:0] s_q, e_q;
  logic          left_found, right_found;
  logic [FA-1:0] left_idx, right_idx;
  logic [OW-1:0] left_start, right_end;

  logic          mod_start, mod_done;
  logic [AB-1:0] mod_rem;
  logic [AB-1:0] pad_q;
  logic [OW-1:0] total_q;

  logic          keep;
  logic [OW-1:0] new_start, new_len, al_off;
  logic          slot_ok;
  logic [FA-1:0] slot;
  logic [OW-1:0] ns, ne;
  logic [OW-1:0] pool_clamp;
  logic [CW-1:0] pool_ext, mask_ext;

  logic [1:0]  res_status;
  logic [31:0] res_pad, res_al, res_tot;
  logic        out_load;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bfba_pkg::REG_POOL_SIZE);
  assign prdata = (paddr[2] == bfba_pkg::REG_POOL_SIZE) ? pool_size : 32'd0;

  assign pool_ext   = CW'(pool_size);
  assign mask_ext   = CW'({OW{1'b1}});
  assign pool_clamp = (pool_ext > mask_ext) ? OW'(mask_ext) : OW'(pool_ext);

  assign {f_st, f_len} = fr_rdata;
  assign {u_st, u_len} = ur_rdata;
  assign f_end = f_st + f_len;

  assign scan_end = (cnt == IW'(SN)) && !pipe_vld;

  assign keep      = best_len > total_q;
  assign new_start = best_start + total_q;
  assign new_len   = best_len - total_q;
  assign al_off    = best_start + OW'(pad_q);

  assign slot_ok = left_found || right_found || fe_found;
  assign slot    = left_found ? left_idx : (right_found ? right_idx : fe_idx);
  assign ns      = left_found ? left_start : s_q;
  assign ne      = right_found ? right_end : e_q;

  // neighbours drop out, merged block takes the slot
  always_comb begin
    fv_merge = free_valid;
    if (left_found) fv_merge[left_idx] = 1'b0;
    if (right_found) fv_merge[right_idx] = 1'b0;
    fv_merge[slot] = 1'b1;
  end

  bfba_ram #(.WIDTH(2*OW), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (cnt[FA-1:0]),
    .rdata (fr_rdata)
  );

  bfba_ram #(.WIDTH(2*OW), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk   (clk),
    .we    (ur_we),
    .waddr (ur_waddr),
    .wdata (ur_wdata),
    .raddr (cnt[UA-1:0]),
    .rdata (ur_rdata)
  );

  bfba_mod #(.DW(OW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (best_start),
    .divisor  (align_q),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfba_pkg::ST_INIT: state_next = bfba_pkg::ST_IDLE;
      bfba_pkg::ST_IDLE: begin
        if (cfg_we) begin
          state_next = bfba_pkg::ST_INIT;
        end else if (in_valid) begin
          unique case (command)
            bfba_pkg::CMD_ALLOC, bfba_pkg::CMD_QUERY: state_next = bfba_pkg::ST_FIT;
            bfba_pkg::CMD_FREE: state_next = bfba_pkg::ST_FIND;
            default: state_next = bfba_pkg::ST_DONE;
          endcase
        end
      end
      bfba_pkg::ST_FIT: begin
        if (scan_end) begin
          if (cmd_q == bfba_pkg::CMD_ALLOC && best_found && ue_found) begin
            state_next = bfba_pkg::ST_MOD;
          end else begin
            state_next = bfba_pkg::ST_DONE;
          end
        end
      end
      bfba_pkg::ST_MOD: if (mod_done) state_next = bfba_pkg::ST_TOTAL;
      bfba_pkg::ST_TOTAL: state_next = bfba_pkg::ST_COMMIT_A;
      bfba_pkg::ST_COMMIT_A: state_next = bfba_pkg::ST_DONE;
      bfba_pkg::ST_FIND: begin
        if (scan_end) begin
          state_next = ub_found ? bfba_pkg::ST_MERGE : bfba_pkg::ST_DONE;
        end
      end
      bfba_pkg::ST_MERGE: if (scan_end) state_next = bfba_pkg::ST_COMMIT_F;
      bfba_pkg::ST_COMMIT_F: state_next = bfba_pkg::ST_DONE;
      bfba_pkg::ST_DONE: if (out_load) state_next = bfba_pkg::ST_IDLE;
      default: state_next = bfba_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    scan_run  = 1'b0;
    mod_start = 1'b0;
    out_load  = 1'b0;
    fr_we     = 1'b0;
    fr_waddr  = '0;
    fr_wdata  = '0;
    ur_we     = 1'b0;
    ur_waddr  = ue_idx;
    ur_wdata  = {best_start, total_q};
    unique case (state)
      bfba_pkg::ST_INIT: begin
        fr_we    = 1'b1;
        fr_wdata = {{OW{1'b0}}, pool_clamp};
      end
      bfba_pkg::ST_IDLE: in_ready = !cfg_we;
      bfba_pkg::ST_FIT, bfba_pkg::ST_FIND, bfba_pkg::ST_MERGE: scan_run = 1'b1;
      bfba_pkg::ST_COMMIT_A: begin
        fr_we    = keep;
        fr_waddr = best_idx;
        fr_wdata = {new_start, new_len};
        ur_we    = 1'b1;
      end
      bfba_pkg::ST_COMMIT_F: begin
        fr_we    = slot_ok;
        fr_waddr = slot;
        fr_wdata = {ns, ne - ns};
      end
      bfba_pkg::ST_DONE: out_load = !out_valid || out_ready;
      default: begin
      end
    endcase
    if (state == bfba_pkg::ST_FIT && scan_end && cmd_q == bfba_pkg::CMD_ALLOC
        && best_found && ue_found) begin
      mod_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfba_pkg::ST_INIT;
      pool_size  <= bfba_pkg::POOL_RESET;
      free_valid <= '0;
      used_valid <= '0;
      out_valid  <= 1'b0;
      cnt        <= '0;
      pipe_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && state == bfba_pkg::ST_IDLE) begin
        pool_size <= pwdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (scan_run && !scan_end) begin
        pipe_vld <= cnt < IW'(SN);
        if (cnt < IW'(SN)) cnt <= cnt + 1'b1;
      end else begin
        pipe_vld <= 1'b0;
        cnt      <= '0;
      end
      unique case (state)
        bfba_pkg::ST_INIT: begin
          free_valid <= FREE_ENTRIES'(pool_clamp != '0);
          used_valid <= '0;
        end
        bfba_pkg::ST_COMMIT_A: begin
          free_valid[best_idx] <= keep;
          used_valid[ue_idx]   <= 1'b1;
        end
        bfba_pkg::ST_COMMIT_F: begin
          if (slot_ok) begin
            free_valid         <= fv_merge;
            used_valid[ub_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    pipe_idx <= cnt;
    if (out_load) begin
      status         <= res_status;
      padding_offset <= res_pad;
      aligned_offset <= res_al;
      total_size     <= res_tot;
    end
    unique case (state)
      bfba_pkg::ST_IDLE: begin
        cmd_q       <= command;
        size_q      <= request_size;
        align_q     <= (alignment == '0) ? AB'(1) : alignment;
        need_q      <= CW'(request_size) + CW'((alignment == '0) ? AB'(1) : alignment);
        rel_q       <= release_offset;
        best_found  <= 1'b0;
        ue_found    <= 1'b0;
        fe_found    <= 1'b0;
        ub_found    <= 1'b0;
        left_found  <= 1'b0;
        right_found <= 1'b0;
        res_status  <= bfba_pkg::STAT_OK;
        res_pad     <= '0;
        res_al      <= '0;
        res_tot     <= '0;
      end
      bfba_pkg::ST_FIT: begin
        if (pipe_vld) begin
          if (pipe_idx < IW'(FREE_ENTRIES) && free_valid[pipe_idx[FA-1:0]]
              && CW'(f_len) >= need_q) begin
            if (!best_found || f_len < best_len
                || (f_len == best_len && f_st < best_start)) begin
              best_found <= 1'b1;
              best_idx   <= pipe_idx[FA-1:0];
              best_start <= f_st;
              best_len   <= f_len;
            end
          end
          if (pipe_idx < IW'(USED_ENTRIES) && !used_valid[pipe_idx[UA-1:0]] && !ue_found) begin
            ue_found <= 1'b1;
            ue_idx   <= pipe_idx[UA-1:0];
          end
        end
        if (scan_end) begin
          if (!best_found) begin
            res_status <= bfba_pkg::STAT_NOFIT;
          end else if (cmd_q == bfba_pkg::CMD_ALLOC && !ue_found) begin
            res_status <= bfba_pkg::STAT_FULL;
          end
        end
      end
      bfba_pkg::ST_MOD: if (mod_done) pad_q <= align_q - mod_rem;
      bfba_pkg::ST_TOTAL: total_q <= OW'(CW'(size_q) + CW'(pad_q));
      bfba_pkg::ST_COMMIT_A: begin
        res_pad <= 32'(best_start);
        res_al  <= 32'(al_off);
        res_tot <= 32'(total_q);
      end
      bfba_pkg::ST_FIND: begin
        if (pipe_vld) begin
          if (pipe_idx < IW'(USED_ENTRIES) && used_valid[pipe_idx[UA-1:0]] && !ub_found
              && CW'(u_st) == CW'(rel_q)) begin
            ub_found <= 1'b1;
            ub_idx   <= pipe_idx[UA-1:0];
            s_q      <= u_st;
            e_q      <= u_st + u_len;
          end
          if (pipe_idx < IW'(FREE_ENTRIES) && !free_valid[pipe_idx[FA-1:0]] && !fe_found) begin
            fe_found <= 1'b1;
            fe_idx   <= pipe_idx[FA-1:0];
          end
        end
        if (scan_end && !ub_found) res_status <= bfba_pkg::STAT_NOTFOUND;
      end
      bfba_pkg::ST_MERGE: begin
        if (pipe_vld && pipe_idx < IW'(FREE_ENTRIES) && free_valid[pipe_idx[FA-1:0]]) begin
          if (!left_found && f_end == s_q) begin
            left_found <= 1'b1;
            left_idx   <= pipe_idx[FA-1:0];
            left_start <= f_st;
          end else if (!right_found && f_st == e_q) begin
            right_found <= 1'b1;
            right_idx   <= pipe_idx[FA-1:0];
            right_end   <= f_end;
          end
        end
      end
      bfba_pkg::ST_COMMIT_F: if (!slot_ok) res_status <= bfba_pkg::STAT_FULL;
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/bfba_ram.sv
module bfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bfba_mod.sv
// Restoring remainder, one dividend bit per cycle.
module bfba_mod #(
  parameter int DW = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DW-1:0]                  dividend,
  input  logic [bfba_pkg::ALIGN_BITS-1:0] divisor,
  output logic                           done,
  output logic [bfba_pkg::ALIGN_BITS-1:0] rem
);

  localparam int VW = bfba_pkg::ALIGN_BITS;
  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   sh;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [VW:0]     trial;

  assign trial = {rem, sh[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (busy) begin
      sh <= sh << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= VW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[VW-1:0];
      end
    end
  end

endmodule

>>> dv/tb.sv
module tb;

  localparam int NSLOT = 64;
  localparam int SETTLE = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = bfba_pkg::CMD_QUERY;
  logic [31:0] request_size = '0;
  logic [16:0] alignment = 17'd1;
  logic [31:0] release_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [31:0] padding_offset, aligned_offset, total_size;

  best_fit_block_allocator i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] cmd;
    logic [31:0] size;
    logic [16:0] align;
    logic [31:0] rel;
  } req_t;

  typedef struct packed {
    logic [1:0] st;
    logic [31:0] pad_off;
    logic [31:0] al_off;
    logic [31:0] tot;
  } grant_t;

  // allocator shadow state
  logic [31:0] fr_start [NSLOT];
  logic [31:0] fr_len [NSLOT];
  bit fr_ok [NSLOT];
  logic [31:0] us_start [NSLOT];
  logic [31:0] us_len [NSLOT];
  bit us_ok [NSLOT];

  req_t pending_reqs[$];
  grant_t expected_grants[$];
  logic [31:0] live_offsets[$];

  int idle_pct = 0, stall_pct = 0;
  int mismatches = 0, beats_in = 0, beats_out = 0, grants_ok = 0;
  longint cycles = 0;

  logic in_ready_seen = 1'b0;
  req_t beat_req;
  grant_t got;

  function automatic void pool_reset(input logic [31:0] pool);
    for (int i = 0; i < NSLOT; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_ok[i] = 0;
      us_start[i] = '0; us_len[i] = '0; us_ok[i] = 0;
    end
    if (pool != 0) begin
      fr_len[0] = pool;
      fr_ok[0] = 1;
    end
    live_offsets.delete();
  endfunction

  function automatic int best_fit(input logic [63:0] need);
    int b;
    b = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!fr_ok[i] || {32'd0, fr_len[i]} < need) continue;
      if (b < 0 || fr_len[i] < fr_len[b] ||
          (fr_len[i] == fr_len[b] && fr_start[i] < fr_start[b])) b = i;
    end
    return b;
  endfunction

  function automatic grant_t allocate_predict(input req_t r);
    grant_t g;
    logic [63:0] al, sz, off, pad, tot, ln;
    int fb, ub;
    g = '0;
    al = (r.align == 0) ? 64'd1 : {47'd0, r.align};
    sz = {32'd0, r.size};
    case (r.cmd)
      bfba_pkg::CMD_ALLOC: begin
        fb = best_fit(sz + al);
        ub = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!us_ok[i]) ub = i;
        if (fb < 0) g.st = bfba_pkg::STAT_NOFIT;
        else if (ub < 0) g.st = bfba_pkg::STAT_FULL;
        else begin
          off = {32'd0, fr_start[fb]};
          ln = {32'd0, fr_len[fb]};
          pad = al - (off % al);
          tot = sz + pad;
          if (ln > tot) begin
            fr_start[fb] = 32'(off + tot);
            fr_len[fb] = 32'(ln - tot);
          end else fr_ok[fb] = 0;
          us_start[ub] = off[31:0]; us_len[ub] = tot[31:0]; us_ok[ub] = 1;
          g.st = bfba_pkg::STAT_OK;
          g.pad_off = off[31:0];
          g.al_off = off[31:0] + pad[31:0];
          g.tot = tot[31:0];
          live_offsets.push_back(off[31:0]);
        end
      end
      bfba_pkg::CMD_FREE: begin
        int u, lf, rt, slot;
        logic [63:0] s, e, ns, ne;
        u = -1; lf = -1; rt = -1;
        for (int i = 0; i < NSLOT; i++)
          if (u < 0 && us_ok[i] && us_start[i] == r.rel) u = i;
        if (u < 0) g.st = bfba_pkg::STAT_NOTFOUND;
        else begin
          s = {32'd0, us_start[u]};
          e = s + {32'd0, us_len[u]};
          for (int i = 0; i < NSLOT; i++) begin
            if (!fr_ok[i]) continue;
            if (lf < 0 && {32'd0, fr_start[i]} + {32'd0, fr_len[i]} == s) lf = i;
            else if (rt < 0 && {32'd0, fr_start[i]} == e) rt = i;
          end
          slot = lf >= 0 ? lf : rt;
          if (slot < 0)
            for (int i = NSLOT - 1; i >= 0; i--) if (!fr_ok[i]) slot = i;
          if (slot < 0) g.st = bfba_pkg::STAT_FULL;
          else begin
            ns = lf >= 0 ? {32'd0, fr_start[lf]} : s;
            ne = rt >= 0 ? {32'd0, fr_start[rt]} + {32'd0, fr_len[rt]} : e;
            if (lf >= 0) fr_ok[lf] = 0;
            if (rt >= 0) fr_ok[rt] = 0;
            fr_start[slot] = ns[31:0]; fr_len[slot] = 32'(ne - ns); fr_ok[slot] = 1;
            us_ok[u] = 0;
            g.st = bfba_pkg::STAT_OK;
            foreach (live_offsets[k])
              if (live_offsets[k] == r.rel) begin
                live_offsets.delete(k);
                break;
              end
          end
        end
      end
      bfba_pkg::CMD_QUERY:
        g.st = best_fit(sz + al) >= 0 ? bfba_pkg::STAT_OK : bfba_pkg::STAT_NOFIT;
      default: g = '0;
    endcase
    return g;
  endfunction

  // driver: payload and valid change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          {command, request_size, alignment, release_offset} <= pending_reqs.pop_front();
        end else in_valid <= 1'b0;
      end
      out_ready <= $urandom_range(99) >= stall_pct;
    end
  end

  // monitor: accepts counted and predicted at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_ready_seen <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      beat_req = {command, request_size, alignment, release_offset};
      expected_grants.push_back(allocate_predict(beat_req));
      beats_in <= beats_in + 1;
    end
    if (!rst && out_valid && out_ready) begin
      got = {status, padding_offset, aligned_offset, total_size};
      beats_out <= beats_out + 1;
      if (expected_grants.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat st=%0d", status);
      end else begin
        if (got !== expected_grants[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp st=%0d pad=%h al=%h tot=%h got st=%0d pad=%h al=%h tot=%h",
                     expected_grants[0].st, expected_grants[0].pad_off,
                     expected_grants[0].al_off, expected_grants[0].tot,
                     got.st, got.pad_off, got.al_off, got.tot);
        end
        if (expected_grants[0].st == bfba_pkg::STAT_OK && expected_grants[0].tot != 0)
          grants_ok <= grants_ok + 1;
        void'(expected_grants.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool(input logic [31:0] pool);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= pool;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    pool_reset(pool);
  endtask

  function automatic req_t rand_req(input logic [31:0] pool);
    req_t r;
    int k;
    r.rel = $urandom;
    r.size = $urandom_range(0, 300);
    r.align = 17'($urandom_range(1, 64));
    k = $urandom_range(99);
    if (k < 3) r.align = 17'($urandom_range(0, 1) ? 0 : 65536);
    else if (k < 6) r.align = 17'($urandom);
    k = $urandom_range(99);
    if (k < 4) r.size = $urandom;
    else if (k < 8) r.size = pool - {15'd0, r.align};
    k = $urandom_range(99);
    if (k < 45) r.cmd = bfba_pkg::CMD_ALLOC;
    else if (k < 80) r.cmd = bfba_pkg::CMD_FREE;
    else if (k < 96) r.cmd = bfba_pkg::CMD_QUERY;
    else r.cmd = 2'd3;
    return r;
  endfunction

  task automatic run_phase(input int n, input logic [31:0] pool, input int ip, input int sp);
    req_t r;
    idle_pct = ip; stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      r = rand_req(pool);
      if (r.cmd == bfba_pkg::CMD_FREE && $urandom_range(99) < 85) begin
        while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
        if (live_offsets.size() != 0)
          r.rel = live_offsets[$urandom_range(live_offsets.size() - 1)];
      end
      pending_reqs.push_back(r);
    end
    wait_drained();
  endtask

  initial begin
    req_t d;
    logic [31:0] pools [5];
    pools = '{32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd700};
    pool_reset(bfba_pkg::POOL_RESET);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes on the reset pool
    d = '{bfba_pkg::CMD_QUERY, 32'd0, 17'd0, 32'd0}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_QUERY, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF};
    pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_ALLOC, 32'd0, 17'd0, 32'd0}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_ALLOC, 32'd100, 17'd65536, 32'd0}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_ALLOC, 32'd10, 17'd7, 32'd0}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 17'd1, 32'd0}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_FREE, 32'd0, 17'd1, 32'd12345}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_FREE, 32'hFFFF_FFFF, 17'h1FFFF, 32'd1}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_FREE, 32'd0, 17'd1, 32'd0}; pending_reqs.push_back(d);
    d = '{2'd3, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF}; pending_reqs.push_back(d);
    d = '{bfba_pkg::CMD_ALLOC, 32'd65000, 17'd1, 32'd0}; pending_reqs.push_back(d);
    wait_drained();
    // used table full: many tiny allocations
    write_pool(32'd1000);
    for (int i = 0; i < 66; i++) begin
      d = '{bfba_pkg::CMD_ALLOC, 32'd0, 17'd1, 32'd0};
      pending_reqs.push_back(d);
    end
    wait_drained();
    // free every other block so no frees touch
    for (int i = 0; i < 64; i += 2) begin
      d = '{bfba_pkg::CMD_FREE, 32'd0, 17'd1, 32'(i)};
      pending_reqs.push_back(d);
    end
    wait_drained();
    run_phase(60, 32'd1000, 0, 0);
    foreach (pools[p]) begin
      write_pool(pools[p]);
      run_phase(40, pools[p], 0, 0);
    end
    write_pool(32'd65536);
    run_phase(150, 32'd65536, 81, 0);
    write_pool(32'd2000);
    run_phase(150, 32'd2000, 0, 81);
    write_pool(32'd300);
    run_phase(100, 32'd300, 23, 23);
    $display("tb: %0d beats in, %0d out, %0d non-empty grants, pool sizes 0 to 2^32-1",
             beats_in, beats_out, grants_ok);
    if (mismatches == 0) $display("tb: success");
    else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
